/* rtl/eatrm_pkg.sv */
// package: word types, fixed-point constants and the quarter-wave sine rom
package eatrm_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_W      = 16;

  localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
  localparam int IDX_W   = ANGLE_BITS - 1;
  localparam int ROM_W   = FRAC_BITS + 1;
  localparam int VAL_W   = FRAC_BITS + 2;
  localparam int SUM_W   = VAL_W + 1;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ONE_Q   = 2 ** FRAC_BITS;

  // convention register values
  localparam logic CONV_XYZ = 1'b0;
  localparam logic CONV_ZXZ = 1'b1;

  localparam real PI_R   = 3.14159265358979323846;
  localparam real TURN_R = 2.0 ** ANGLE_BITS;
  localparam real ONE_R  = 2.0 ** FRAC_BITS;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_first;
    logic [ANGLE_BITS-1:0] angle_second;
    logic [ANGLE_BITS-1:0] angle_third;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } matrix_t;

  typedef logic [ROM_W-1:0] sin_rom_t [0:QUARTER];

  // round(2^FRAC_BITS * sin(2*pi*k/turn)), built at elaboration
  function automatic sin_rom_t sin_rom_init();
    sin_rom_t rom;
    real      x;
    for (int k = 0; k <= QUARTER; k++) begin
      x = $sin(2.0 * PI_R * k / TURN_R);
      rom[k] = ROM_W'($rtoi(x * ONE_R + 0.5));
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = sin_rom_init();

endpackage

/* rtl/euler_angles_to_rotation_matrix.sv */
// top level: five-stage pipeline from three binary angles to a q14 rotation matrix
//
// Takes one angle word per cycle and returns its nine-element matrix word
// through the five registered stages, for every item, in order. The stages
// are the sine rom read, sign fix-up, the first bank of ten multipliers, the
// second bank of four multipliers, and the saturating adders.
// busy stays low, so start may be held high continuously; done is a single-cycle
// strobe and result must be captured on it. convention (0 x-y-z, 1 z-x-z) is
// used by stages three to five directly, so change it only with the pipeline empty.
module euler_angles_to_rotation_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  eatrm_pkg::angles_t angles,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  output logic              done,
  output eatrm_pkg::matrix_t result
);

  localparam int VW = eatrm_pkg::VAL_W;
  localparam int SW = eatrm_pkg::SUM_W;
  localparam int PW = eatrm_pkg::PROD_W;

  function automatic logic [eatrm_pkg::IDX_W-1:0] rom_index(
    input logic [eatrm_pkg::ANGLE_BITS-1:0] a
  );
    logic [eatrm_pkg::IDX_W-1:0] r;
    r = {1'b0, a[eatrm_pkg::ANGLE_BITS-3:0]};
    if (a[eatrm_pkg::ANGLE_BITS-2]) begin
      return eatrm_pkg::IDX_W'(eatrm_pkg::QUARTER) - r;
    end
    return r;
  endfunction

  function automatic logic signed [VW-1:0] rmul(
    input logic signed [VW-1:0] a,
    input logic signed [VW-1:0] b
  );
    logic signed [PW-1:0] p;
    p = a * b;
    p = p + PW'(2 ** (eatrm_pkg::FRAC_BITS - 1));
    return VW'(p >>> eatrm_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [VW-1:0] sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] lim;
    lim = SW'(eatrm_pkg::ONE_Q);
    if (s > lim) begin
      return VW'(lim);
    end
    if (s < -lim) begin
      return VW'(-lim);
    end
    return VW'(s);
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [VW-1:0] v);
    return SW'(v);
  endfunction

  function automatic logic signed [eatrm_pkg::OUT_W-1:0] to_out(
    input logic signed [VW-1:0] v
  );
    return eatrm_pkg::OUT_W'(v);
  endfunction

  logic convention;

  always_ff @(posedge clk) begin
    if (rst) begin
      convention <= eatrm_pkg::CONV_XYZ;
    end else if (cfg_wr_en) begin
      convention <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // rom addressing
  logic [eatrm_pkg::ANGLE_BITS-1:0] ang     [3];
  logic [eatrm_pkg::ANGLE_BITS-1:0] ang_cos [3];
  logic [eatrm_pkg::IDX_W-1:0]      sin_idx [3];
  logic [eatrm_pkg::IDX_W-1:0]      cos_idx [3];

  assign ang[0] = angles.angle_first;
  assign ang[1] = angles.angle_second;
  assign ang[2] = angles.angle_third;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ang_cos[i] = ang[i] + eatrm_pkg::ANGLE_BITS'(eatrm_pkg::QUARTER);
      sin_idx[i] = rom_index(ang[i]);
      cos_idx[i] = rom_index(ang_cos[i]);
    end
  end

  // stage 1: rom read
  logic                        v1;
  logic [eatrm_pkg::ROM_W-1:0] mag_s [3];
  logic [eatrm_pkg::ROM_W-1:0] mag_c [3];
  logic                        neg_s [3];
  logic                        neg_c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_s[i] <= eatrm_pkg::SIN_ROM[sin_idx[i]];
      mag_c[i] <= eatrm_pkg::SIN_ROM[cos_idx[i]];
      neg_s[i] <= ang[i][eatrm_pkg::ANGLE_BITS-1];
      neg_c[i] <= ang_cos[i][eatrm_pkg::ANGLE_BITS-1];
    end
  end

  // stage 2: signed sine and cosine
  logic                 v2;
  logic signed [VW-1:0] sn [3];
  logic signed [VW-1:0] cs [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sn[i] <= neg_s[i] ? -$signed({1'b0, mag_s[i]}) : $signed({1'b0, mag_s[i]});
      cs[i] <= neg_c[i] ? -$signed({1'b0, mag_c[i]}) : $signed({1'b0, mag_c[i]});
    end
  end

  // stage 3: first product bank
  logic signed [VW-1:0] opa [10];
  logic signed [VW-1:0] opb [10];

  always_comb begin
    if (convention == eatrm_pkg::CONV_XYZ) begin
      opa[0] = cs[0];  opb[0] = sn[1];
      opa[1] = sn[0];  opb[1] = sn[1];
      opa[2] = cs[1];  opb[2] = cs[2];
      opa[3] = -cs[1]; opb[3] = sn[2];
      opa[4] = -sn[0]; opb[4] = cs[1];
      opa[5] = cs[0];  opb[5] = cs[1];
      opa[6] = cs[0];  opb[6] = sn[2];
      opa[7] = cs[0];  opb[7] = cs[2];
      opa[8] = sn[0];  opb[8] = sn[2];
      opa[9] = sn[0];  opb[9] = cs[2];
    end else begin
      opa[0] = sn[0];  opb[0] = cs[1];
      opa[1] = cs[0];  opb[1] = cs[1];
      opa[2] = cs[0];  opb[2] = cs[2];
      opa[3] = -cs[0]; opb[3] = sn[2];
      opa[4] = sn[1];  opb[4] = sn[0];
      opa[5] = sn[0];  opb[5] = cs[2];
      opa[6] = -sn[0]; opb[6] = sn[2];
      opa[7] = -sn[1]; opb[7] = cs[0];
      opa[8] = sn[1];  opb[8] = sn[2];
      opa[9] = sn[1];  opb[9] = cs[2];
    end
  end

  logic                 v3;
  logic signed [VW-1:0] p3   [10];
  logic signed [VW-1:0] s2_3;
  logic signed [VW-1:0] c2_3;
  logic signed [VW-1:0] s3_3;
  logic signed [VW-1:0] c3_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 10; i++) begin
      p3[i] <= rmul(opa[i], opb[i]);
    end
    s2_3 <= sn[1];
    c2_3 <= cs[1];
    s3_3 <= sn[2];
    c3_3 <= cs[2];
  end

  // stage 4: second product bank
  logic signed [VW-1:0] qa [4];
  logic signed [VW-1:0] qb [4];

  always_comb begin
    if (convention == eatrm_pkg::CONV_XYZ) begin
      qa[0] = p3[1];  qb[0] = c3_3;
      qa[1] = -p3[1]; qb[1] = s3_3;
      qa[2] = -p3[0]; qb[2] = c3_3;
      qa[3] = p3[0];  qb[3] = s3_3;
    end else begin
      qa[0] = p3[0];  qb[0] = s3_3;
      qa[1] = p3[0];  qb[1] = c3_3;
      qa[2] = p3[1];  qb[2] = s3_3;
      qa[3] = p3[1];  qb[3] = c3_3;
    end
  end

  logic                 v4;
  logic signed [VW-1:0] q4   [4];
  logic signed [VW-1:0] p4   [10];
  logic signed [VW-1:0] s2_4;
  logic signed [VW-1:0] c2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q4[i] <= rmul(qa[i], qb[i]);
    end
    p4   <= p3;
    s2_4 <= s2_3;
    c2_4 <= c2_3;
  end

  // stage 5: saturating sums and output word
  eatrm_pkg::matrix_t result_next;

  always_comb begin
    if (convention == eatrm_pkg::CONV_XYZ) begin
      result_next.m00 = to_out(p4[2]);
      result_next.m01 = to_out(p4[3]);
      result_next.m02 = to_out(s2_4);
      result_next.m10 = to_out(sat(ext(q4[0]) + ext(p4[6])));
      result_next.m11 = to_out(sat(ext(q4[1]) + ext(p4[7])));
      result_next.m12 = to_out(p4[4]);
      result_next.m20 = to_out(sat(ext(q4[2]) + ext(p4[8])));
      result_next.m21 = to_out(sat(ext(q4[3]) + ext(p4[9])));
      result_next.m22 = to_out(p4[5]);
    end else begin
      result_next.m00 = to_out(sat(ext(p4[2]) - ext(q4[0])));
      result_next.m01 = to_out(sat(ext(p4[3]) - ext(q4[1])));
      result_next.m02 = to_out(p4[4]);
      result_next.m10 = to_out(sat(ext(p4[5]) + ext(q4[2])));
      result_next.m11 = to_out(sat(ext(p4[6]) + ext(q4[3])));
      result_next.m12 = to_out(p4[7]);
      result_next.m20 = to_out(p4[8]);
      result_next.m21 = to_out(p4[9]);
      result_next.m22 = to_out(c2_4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
